@@ hdl/isu_pkg.sv @@
// ----------------------------------------------------------------------------
// isu_pkg: shared types and codes of the indexed stack table
// Request and response payloads, request and status codes, and the command
// and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package isu_pkg;

  localparam int unsigned DEPTH_DEF     = 1024;
  localparam int unsigned WORD_BITS_DEF = 32;

  localparam int unsigned OP_BITS   = 3;
  localparam int unsigned POS_BITS  = 10;
  localparam int unsigned VAL_BITS  = 32;
  localparam int unsigned CNT_BITS  = 11;
  localparam int unsigned STAT_BITS = 2;

  // request codes
  localparam logic [OP_BITS-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_BITS-1:0] OP_POP    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_GET    = 3'd2;
  localparam logic [OP_BITS-1:0] OP_SET    = 3'd3;
  localparam logic [OP_BITS-1:0] OP_FILL   = 3'd4;
  localparam logic [OP_BITS-1:0] OP_SEARCH = 3'd5;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd6;

  // status codes
  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_BITS-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [OP_BITS-1:0]  req_type;
    logic [POS_BITS-1:0] position;
    logic [VAL_BITS-1:0] value;
  } req_t;

  typedef struct packed {
    logic [VAL_BITS-1:0]  read_word;
    logic                 hit;
    logic [POS_BITS-1:0]  found_at;
    logic [CNT_BITS-1:0]  count;
    logic                 is_empty;
    logic [STAT_BITS-1:0] status;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch request, start read, set up walk
    logic step;     // advance the walk by one entry
    logic load;     // commit count and load the response register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic done;     // request work finished, result ready to load
  } sts_t;

endpackage

@@ hdl/isu_stream_if.sv @@
// ----------------------------------------------------------------------------
// isu_stream_if: valid/ready channel
// Carries one payload per request; a request moves when valid and ready
// are both high at a rising clock edge.
// ----------------------------------------------------------------------------
interface isu_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/isu_ctrl.sv @@
// ----------------------------------------------------------------------------
// isu_ctrl: request sequencer
// Accepts a request, lets the datapath run until it reports done, and loads
// the response register once it is free.
// ----------------------------------------------------------------------------
module isu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output isu_pkg::cmd_t cmd_o,
  input  isu_pkg::sts_t sts_i
);
  import isu_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;

  assign in_ready_o = (state_q == S_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = in_valid_i && in_ready_o;
    state_d       = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.capture) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o.step = !sts_i.done;
        cmd_o.load = sts_i.done && slot_free;
        if (cmd_o.load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hdl/isu_dp.sv @@
// ----------------------------------------------------------------------------
// isu_dp: entry store, fill count and walk datapath
// Word store with a write port and a registered read port, a walk index
// that drives writes (push, set with padding, fill) and reads (search),
// and the response register.
// ----------------------------------------------------------------------------
module isu_dp #(
  parameter int unsigned DEPTH     = isu_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = isu_pkg::WORD_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  isu_pkg::req_t req_i,
  input  isu_pkg::cmd_t cmd_i,
  output isu_pkg::sts_t sts_o,
  output isu_pkg::rsp_t rsp_o
);
  import isu_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WORD_BITS-1:0] mem [DEPTH];

  logic [OP_BITS-1:0]   op_q;
  logic [POS_BITS-1:0]  pos_q;
  logic [WORD_BITS-1:0] val_q;
  logic [WORD_BITS-1:0] rdata_q;

  logic [CW-1:0] cnt_q, cnt_d, cnt_new;
  logic [CW-1:0] idx_q, idx_d, end_q, end_d, pidx_q;
  logic [CW-1:0] idx_init, end_init, cnt_dec;
  logic          pend_q, pend_d;

  logic                 rd_en, wr_en;
  logic [AW-1:0]        rd_addr, wr_addr;
  logic [WORD_BITS-1:0] wr_data;

  logic full, empty, more, is_write, is_search, match;
  logic in_pos_ok, in_pos_lt;
  rsp_t res, rsp_q;

  assign full      = (32'(cnt_q) == 32'(DEPTH));
  assign empty     = (cnt_q == '0);
  assign cnt_dec   = cnt_q - 1'b1;
  assign in_pos_ok = (32'(req_i.position) < 32'(DEPTH));
  assign in_pos_lt = (32'(req_i.position) < 32'(cnt_q));

  // walk bounds for the incoming request
  always_comb begin
    idx_init = '0;
    end_init = '0;
    case (req_i.req_type)
      OP_PUSH: begin
        idx_init = cnt_q;
        end_init = full ? cnt_q : cnt_q + 1'b1;
      end
      OP_SET: begin
        // below the count: one write; at or past it: zero pad up to position
        idx_init = in_pos_lt ? CW'(req_i.position) : cnt_q;
        end_init = in_pos_ok ? CW'(req_i.position) + 1'b1 : idx_init;
      end
      OP_FILL, OP_SEARCH: begin
        idx_init = '0;
        end_init = cnt_q;
      end
      default: begin
        idx_init = '0;
        end_init = '0;
      end
    endcase
  end

  assign more      = (idx_q < end_q);
  assign is_write  = (op_q == OP_PUSH) || (op_q == OP_SET) || (op_q == OP_FILL);
  assign is_search = (op_q == OP_SEARCH);
  assign match     = pend_q && (rdata_q == val_q);

  assign wr_en   = cmd_i.step && is_write && more;
  assign wr_addr = idx_q[AW-1:0];
  assign wr_data = ((op_q == OP_SET) && (32'(idx_q) != 32'(pos_q))) ? '0 : val_q;

  // read at capture serves pop and get; search reads along the walk
  assign rd_en = cmd_i.capture || (cmd_i.step && is_search && more);
  always_comb begin
    if (cmd_i.capture) begin
      rd_addr = (req_i.req_type == OP_POP) ? cnt_dec[AW-1:0] : AW'(req_i.position);
    end else begin
      rd_addr = idx_q[AW-1:0];
    end
  end

  always_comb begin
    idx_d  = idx_q;
    end_d  = end_q;
    pend_d = pend_q;
    if (cmd_i.capture) begin
      idx_d  = idx_init;
      end_d  = end_init;
      pend_d = 1'b0;
    end else if (cmd_i.step) begin
      if (more) begin
        idx_d = idx_q + 1'b1;
      end
      if (is_search) begin
        pend_d = more;
      end
    end
  end

  always_comb begin
    case (op_q)
      OP_PUSH, OP_SET, OP_FILL: sts_o.done = !more;
      OP_SEARCH:                sts_o.done = match || (!pend_q && !more);
      default:                  sts_o.done = 1'b1;
    endcase
  end

  // response and new count
  always_comb begin
    res     = '0;
    cnt_new = cnt_q;
    res.status = ST_OK;
    case (op_q)
      OP_PUSH: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          cnt_new = cnt_q + 1'b1;
        end
      end
      OP_POP: begin
        if (empty) begin
          res.status = ST_EMPTY;
        end else begin
          res.read_word = VAL_BITS'(rdata_q);
          cnt_new       = cnt_dec;
        end
      end
      OP_GET: begin
        if (32'(pos_q) < 32'(cnt_q)) begin
          res.read_word = VAL_BITS'(rdata_q);
        end else begin
          res.status = ST_RANGE;
        end
      end
      OP_SET: begin
        if (32'(pos_q) >= 32'(DEPTH)) begin
          res.status = ST_RANGE;
        end else if (32'(pos_q) >= 32'(cnt_q)) begin
          cnt_new = CW'(pos_q) + 1'b1;
        end
      end
      OP_SEARCH: begin
        res.hit      = match;
        res.found_at = match ? POS_BITS'(pidx_q) : '0;
      end
      OP_CLEAR: begin
        cnt_new = '0;
      end
      default: begin
        cnt_new = cnt_q;
      end
    endcase
    res.count    = CNT_BITS'(cnt_new);
    res.is_empty = (cnt_new == '0);
  end

  assign cnt_d = cmd_i.load ? cnt_new : cnt_q;
  assign rsp_o = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pend_q <= 1'b0;
      idx_q  <= '0;
      end_q  <= '0;
    end else begin
      cnt_q  <= cnt_d;
      pend_q <= pend_d;
      idx_q  <= idx_d;
      end_q  <= end_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= req_i.req_type;
      pos_q <= req_i.position;
      val_q <= WORD_BITS'(req_i.value);
    end
    if (cmd_i.step && is_search && more) begin
      pidx_q <= idx_q;
    end
    if (cmd_i.load) begin
      rsp_q <= res;
    end
  end

  // entry store
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/indexed_stack_table_unit.sv @@
// ----------------------------------------------------------------------------
// indexed_stack_table_unit: bounded word vector with fill count and search
// Top level: request and response channels around the sequencer and the
// store datapath.
// ----------------------------------------------------------------------------
// One request at a time. Pop, get, clear, an unused code and a push into a
// full table write nothing to the store; push and a set inside the count
// make one store write. Set past the count writes the padding words and the
// new word one per cycle. Fill writes every occupied entry one per cycle.
// Search reads one entry per cycle through the store read port with
// registered read data. The request channel is ready again the cycle after
// the response is loaded; a finished response waits in its own register,
// so a new request may be taken while it is pending.
// The store is not cleared at reset; the fill count is.
// ----------------------------------------------------------------------------
module indexed_stack_table_unit #(
  parameter int unsigned DEPTH     = isu_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = isu_pkg::WORD_BITS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  isu_stream_if.sink   req_i,   // payload isu_pkg::req_t
  isu_stream_if.source rsp_o    // payload isu_pkg::rsp_t
);
  import isu_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp_data;

  // sequencer: idle / execute, owns both handshakes
  isu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // datapath: store, fill count, walk index, response register
  isu_dp #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i.data),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_data)
  );

  assign rsp_o.data = rsp_data;

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for indexed_stack_table_unit
// Drives push, pop, get, set, fill, search, clear and the unused request code
// through the request channel, keeps a shadow copy of the table to predict
// every response, and compares each response field by field in order.
// ----------------------------------------------------------------------------
module tb;
  import isu_pkg::*;

  localparam int unsigned TABLE_DEPTH = DEPTH_DEF;
  localparam int unsigned STUCK_LIMIT = 6000;
  localparam int unsigned RANDOM_ITEMS = 1250;
  localparam int unsigned QUIET_TAIL   = 150;   // last requests run with no idling
  localparam logic [OP_BITS-1:0] OP_UNUSED = 3'd7;

  logic clk;
  logic rst_n;

  isu_stream_if #(.payload_t(req_t)) req_if ();
  isu_stream_if #(.payload_t(rsp_t)) rsp_if ();

  indexed_stack_table_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow of the table contents and fill count
  logic [VAL_BITS-1:0] shadow_words [TABLE_DEPTH];
  int unsigned         shadow_count;

  // responses predicted for accepted requests, oldest first
  rsp_t        pending_rsps[$];
  int unsigned fail_count;
  int unsigned stuck_cycles;
  int unsigned stall_left;
  bit          idling_on;

  always #10 clk = ~clk;

  // predict one response and advance the shadow state
  function automatic rsp_t apply_table_op(input req_t r);
    rsp_t        o;
    int unsigned i;
    o = '0;
    case (r.req_type)
      OP_PUSH: begin
        if (shadow_count >= TABLE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          shadow_words[shadow_count] = r.value;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          o.status = ST_EMPTY;
        end else begin
          shadow_count--;
          o.read_word = shadow_words[shadow_count];
        end
      end
      OP_GET: begin
        if (r.position >= shadow_count) begin
          o.status = ST_RANGE;
        end else begin
          o.read_word = shadow_words[r.position];
        end
      end
      OP_SET: begin
        // a set past the end zero-pads the gap first
        for (i = shadow_count; i < r.position; i++) shadow_words[i] = '0;
        if (r.position >= shadow_count) shadow_count = r.position + 1;
        shadow_words[r.position] = r.value;
      end
      OP_FILL: begin
        for (i = 0; i < shadow_count; i++) shadow_words[i] = r.value;
      end
      OP_SEARCH: begin
        for (i = 0; i < shadow_count; i++) begin
          if (shadow_words[i] == r.value) begin
            o.hit      = 1'b1;
            o.found_at = i[POS_BITS-1:0];
            break;
          end
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
      end
      default: begin
        // unused code leaves everything alone
      end
    endcase
    o.count    = shadow_count[CNT_BITS-1:0];
    o.is_empty = (shadow_count == 0);
    return o;
  endfunction

  function automatic string rsp_text(input rsp_t r);
    return $sformatf("read_word=%h hit=%b found_at=%0d count=%0d is_empty=%b status=%0d",
                     r.read_word, r.hit, r.found_at, r.count, r.is_empty, r.status);
  endfunction

  function automatic req_t make_req(input logic [OP_BITS-1:0] op,
                                    input logic [POS_BITS-1:0] pos,
                                    input logic [VAL_BITS-1:0] val);
    req_t r;
    r.req_type = op;
    r.position = pos;
    r.value    = val;
    return r;
  endfunction

  // words biased toward repeats so that searches hit often
  function automatic logic [VAL_BITS-1:0] random_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2, 3:    return VAL_BITS'($urandom_range(0, 15));
      default: return $urandom;
    endcase
  endfunction

  // mostly well-formed requests that keep the table small, with rare deep sets
  function automatic req_t random_request();
    req_t        r;
    int unsigned pick;
    int unsigned reach;
    pick       = $urandom_range(0, 99);
    r.position = POS_BITS'($urandom_range(0, TABLE_DEPTH - 1));
    r.value    = random_word();
    if (shadow_count > 128 && $urandom_range(0, 3) == 0) begin
      r.req_type = OP_CLEAR;
    end else if (pick < 28) begin
      r.req_type = (shadow_count > 96) ? OP_POP : OP_PUSH;
    end else if (pick < 43) begin
      r.req_type = OP_POP;
    end else if (pick < 58) begin
      r.req_type = OP_GET;
      if (shadow_count != 0 && $urandom_range(0, 7) != 0)
        r.position = POS_BITS'($urandom_range(0, shadow_count - 1));
    end else if (pick < 70) begin
      r.req_type = OP_SET;
      if ($urandom_range(0, 59) != 0) begin
        reach = shadow_count + 4;
        if (reach > TABLE_DEPTH - 1) reach = TABLE_DEPTH - 1;
        r.position = POS_BITS'($urandom_range(0, reach));
      end
    end else if (pick < 77) begin
      r.req_type = OP_FILL;
    end else if (pick < 92) begin
      r.req_type = OP_SEARCH;
      if (shadow_count != 0 && $urandom_range(0, 1) == 1)
        r.value = shadow_words[$urandom_range(0, shadow_count - 1)];
    end else if (pick < 96) begin
      r.req_type = OP_CLEAR;
    end else begin
      r.req_type = OP_UNUSED;
    end
    return r;
  endfunction

  // present one request from the falling edge and hold it until it is taken
  task automatic send_request(input req_t r);
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.data  <= r;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    pending_rsps.push_back(apply_table_op(r));
  endtask

  task automatic idle_requests(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
  endtask

  // hold off until every outstanding response is back
  task automatic wait_for_responses();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%s", what);
  endtask

  task automatic check_response(input rsp_t got);
    rsp_t want;
    if (pending_rsps.size() == 0) begin
      note_failure({"unexpected response: ", rsp_text(got)});
    end else begin
      want = pending_rsps.pop_front();
      if (got.read_word !== want.read_word || got.hit !== want.hit ||
          got.found_at !== want.found_at || got.count !== want.count ||
          got.is_empty !== want.is_empty || got.status !== want.status)
        note_failure({"mismatch: expected ", rsp_text(want), "\n          got      ",
                      rsp_text(got)});
    end
  endtask

  // response side: stall bursts start at random while idling is on
  always @(negedge clk) begin
    if (stall_left != 0) begin
      rsp_if.ready <= 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      rsp_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      rsp_if.ready <= 1'b1;
    end
  end

  // response checker and stuck-run watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_response(rsp_if.data);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("watchdog: nothing moved for %0d cycles, %0d responses outstanding",
                   STUCK_LIMIT, pending_rsps.size());
          $display("tb NOT OK");
          $finish;
        end
      end
    end
  end

  // empty table: pop underflow, get out of range, search miss, fill and
  // clear with nothing stored, and the unused request code
  task automatic test_empty_table();
    send_request(make_req(OP_POP, '0, '0));
    send_request(make_req(OP_GET, '0, '0));
    send_request(make_req(OP_SEARCH, '0, '0));
    send_request(make_req(OP_FILL, '0, '1));
    send_request(make_req(OP_CLEAR, '1, '1));
    send_request(make_req(OP_UNUSED, '1, '1));
  endtask

  // push, get, set inside the count, search hit, pops in stack order
  task automatic test_push_pop();
    send_request(make_req(OP_PUSH, '0, '0));
    send_request(make_req(OP_PUSH, '0, '1));
    send_request(make_req(OP_PUSH, '0, 32'ha5a5_5a5a));
    send_request(make_req(OP_GET, 10'd1, '0));
    send_request(make_req(OP_GET, 10'd3, '0));
    send_request(make_req(OP_SET, 10'd0, 32'h0000_1234));
    send_request(make_req(OP_SEARCH, '0, 32'ha5a5_5a5a));
    send_request(make_req(OP_POP, '0, '0));
    send_request(make_req(OP_POP, '0, '0));
    send_request(make_req(OP_POP, '0, '0));
  endtask

  // set past the end pads with zeros, fill rewrites the padded words
  task automatic test_set_padding();
    send_request(make_req(OP_SET, 10'd4, 32'hcafe_f00d));
    send_request(make_req(OP_GET, 10'd2, '0));
    send_request(make_req(OP_SEARCH, '0, '0));
    send_request(make_req(OP_FILL, '0, 32'h0000_0007));
    send_request(make_req(OP_CLEAR, '0, '0));
  endtask

  // table at its last position: full push, search hit at the top, full-length
  // miss, fill of every entry
  task automatic test_full_table();
    send_request(make_req(OP_SET, '1, 32'h8000_0001));
    send_request(make_req(OP_PUSH, '0, '1));
    send_request(make_req(OP_SEARCH, '0, 32'h8000_0001));
    send_request(make_req(OP_FILL, '0, 32'h5555_5555));
    send_request(make_req(OP_POP, '0, '0));
    send_request(make_req(OP_PUSH, '0, '1));
    send_request(make_req(OP_SEARCH, '0, 32'h0000_0001));
    send_request(make_req(OP_CLEAR, '0, '0));
  endtask

  // random requests; idling alternates in stretches of 100 and stops for the
  // tail, and halfway the sender holds off until the table is quiet
  task automatic test_random_ops(input int unsigned n_items);
    int unsigned i;
    for (i = 0; i < n_items; i++) begin
      idling_on = (i < n_items - QUIET_TAIL) && ((i / 100) % 2 == 0);
      if (i == n_items / 2) wait_for_responses();
      if (idling_on && $urandom_range(0, 4) == 0) idle_requests($urandom_range(1, 8));
      send_request(random_request());
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    rsp_if.ready = 1'b0;
    shadow_count = 0;
    fail_count   = 0;
    stuck_cycles = 0;
    stall_left   = 0;
    idling_on    = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_table();
    test_push_pop();
    test_set_padding();
    test_full_table();
    test_random_ops(RANDOM_ITEMS);

    // drain, then a short settle for any stray response
    wait_for_responses();
    repeat (16) @(posedge clk);
    fail_count += pending_rsps.size();
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/isu_pkg.sv
hdl/isu_stream_if.sv
hdl/isu_ctrl.sv
hdl/isu_dp.sv
hdl/indexed_stack_table_unit.sv
test/tb.sv
